// ----- rtl/core/cscs_pkg.sv -----
// Package for the current-sense offset calibration and scaling core.
// Holds widths, command/status/event codes, register indexes and shared types.
// No dependencies.
package cscs_pkg;

  localparam int NCH          = 5;
  localparam int RAW_W        = 16;
  localparam int DELTA_W      = RAW_W + 1;
  localparam int CUR_W        = 16;
  localparam int FS_W         = 15;
  localparam int TO_W         = 16;
  localparam int TICK_W       = 17;
  localparam int CNT_W        = 32;
  localparam int ZERO_SAMPLES = 64;
  localparam int ZS_SHIFT     = $clog2(ZERO_SAMPLES);
  localparam int SUM_W        = RAW_W + ZS_SHIFT;
  localparam int CALC_W       = $clog2(ZERO_SAMPLES + 1);
  localparam int PROD_W       = 32;
  localparam int ADC_FULL_SCALE = 65535;

  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  // stream payloads
  localparam int CMD_W        = 2;
  localparam int STAT_W       = 2;
  localparam int EV_W         = 2;
  localparam int SW_BIT       = NCH * RAW_W;
  localparam int IN_TDATA_W   = ((SW_BIT + 1 + 7) / 8) * 8;
  localparam int STAT_LSB     = NCH * CUR_W;
  localparam int SCNT_LSB     = STAT_LSB + STAT_W;
  localparam int EV_LSB       = SCNT_LSB + CNT_W;
  localparam int OUT_TDATA_W  = ((EV_LSB + EV_W + 7) / 8) * 8;

  // configuration port
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;
  localparam int REG_IDX_W    = 2;

  localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STALE_TO   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE     = 2'd2;

  localparam logic [FS_W-1:0] FS_RESET = 15'd22000;
  localparam logic [TO_W-1:0] TO_RESET = 16'd10;

  localparam logic [CMD_W-1:0] CMD_CONV = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CAL  = 2'd2;

  localparam logic [STAT_W-1:0] ST_STOPPED = 2'd0;
  localparam logic [STAT_W-1:0] ST_RUNNING = 2'd1;
  localparam logic [STAT_W-1:0] ST_STALE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_CAL     = 2'd3;

  localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EV_W-1:0] EV_ACCEPT = 2'd1;
  localparam logic [EV_W-1:0] EV_REFUSE = 2'd2;
  localparam logic [EV_W-1:0] EV_DONE   = 2'd3;

  // one classified request, queued between front and back
  typedef struct packed {
    logic [NCH-1:0][DELTA_W-1:0] delta;
    logic [STAT_W-1:0]           status;
    logic [CNT_W-1:0]            count;
    logic [EV_W-1:0]             event_code;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- rtl/core/cscs_fifo.sv -----
// Short request queue between front and back of the current-sense core.
// Depends on cscs_pkg (item_t, fifo_stat_t, FIFO_DEPTH).
module cscs_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  cscs_pkg::item_t       push_data_i,
  input  logic                  pop_i,
  output cscs_pkg::item_t       pop_data_o,
  output cscs_pkg::fifo_stat_t  stat_o
);
  import cscs_pkg::*;

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_nxt;

  assign stat_o.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_r == '0);
  assign pop_data_o   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/cscs_front.sv -----
// Front end: configuration registers, request decode and all block state
// (offsets, calibration averaging, counters). Pushes one item per request.
// Depends on cscs_pkg.
module cscs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cscs_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [cscs_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [cscs_pkg::DATA_W-1:0]       cfg_prdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cscs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [cscs_pkg::CMD_W-1:0]        in_tuser,
  input  cscs_pkg::fifo_stat_t              fifo_stat_i,
  output logic                              push_o,
  output cscs_pkg::item_t                   item_o,
  output logic [cscs_pkg::FS_W-1:0]         full_scale_o
);
  import cscs_pkg::*;

  logic [FS_W-1:0]   fs_r;
  logic [TO_W-1:0]   to_r;
  logic              en_r;

  logic [RAW_W-1:0]  zero_r     [NCH];
  logic [RAW_W-1:0]  zero_nxt   [NCH];
  logic [SUM_W-1:0]  sum_r      [NCH];
  logic [SUM_W-1:0]  sum_nxt    [NCH];
  logic [RAW_W-1:0]  last_r     [NCH];
  logic [RAW_W-1:0]  last_nxt   [NCH];
  logic [RAW_W-1:0]  raw        [NCH];
  logic [CALC_W-1:0] calc_r;
  logic [CALC_W-1:0] calc_nxt;
  logic              cal_r;
  logic              cal_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [TICK_W-1:0] ticks_r;
  logic [TICK_W-1:0] ticks_nxt;
  logic [EV_W-1:0]   ev;
  logic              accept;
  logic              cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign in_tready    = !fifo_stat_i.full;
  assign accept       = in_tvalid && in_tready;
  assign push_o       = accept;
  assign full_scale_o = fs_r;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx      = cfg_paddr[ADDR_W-1:2];

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      raw[i] = in_tdata[i*RAW_W +: RAW_W];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FULL_SCALE: cfg_prdata = DATA_W'(fs_r);
      REG_STALE_TO:   cfg_prdata = DATA_W'(to_r);
      REG_ENABLE:     cfg_prdata = DATA_W'(en_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_comb begin
    zero_nxt  = zero_r;
    sum_nxt   = sum_r;
    last_nxt  = last_r;
    calc_nxt  = calc_r;
    cal_nxt   = cal_r;
    cnt_nxt   = cnt_r;
    ticks_nxt = ticks_r;
    ev        = EV_NONE;
    if (accept) begin
      unique case (in_tuser)
        CMD_CONV: begin
          last_nxt  = raw;
          cnt_nxt   = cnt_r + 1'b1;
          ticks_nxt = '0;
          if (cal_r) begin
            for (int i = 0; i < NCH; i++) begin
              sum_nxt[i] = sum_r[i] + SUM_W'(raw[i]);
            end
            calc_nxt = calc_r + 1'b1;
            if (calc_nxt == CALC_W'(ZERO_SAMPLES)) begin
              // average done: load new offsets and leave calibration
              for (int i = 0; i < NCH; i++) begin
                zero_nxt[i] = RAW_W'(sum_nxt[i] >> ZS_SHIFT);
                sum_nxt[i]  = '0;
              end
              calc_nxt = '0;
              cal_nxt  = 1'b0;
              ev       = EV_DONE;
            end
          end
        end
        CMD_TICK: begin
          if (ticks_r != {TICK_W{1'b1}}) begin
            ticks_nxt = ticks_r + 1'b1;
          end
        end
        CMD_CAL: begin
          if (in_tdata[SW_BIT]) begin
            ev = EV_REFUSE;
          end else begin
            for (int i = 0; i < NCH; i++) begin
              sum_nxt[i] = '0;
            end
            calc_nxt = '0;
            cal_nxt  = 1'b1;
            ev       = EV_ACCEPT;
          end
        end
        default: begin
          ev = EV_NONE;
        end
      endcase
    end
    // starting sensing restarts the set count and the stale timer
    if (cfg_wr && reg_idx == REG_ENABLE && cfg_pwdata[0] && !en_r) begin
      cnt_nxt   = '0;
      ticks_nxt = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      item_o.delta[i] = {1'b0, last_nxt[i]} - {1'b0, zero_nxt[i]};
    end
    if (cal_nxt) begin
      item_o.status = ST_CAL;
    end else if (!en_r) begin
      item_o.status = ST_STOPPED;
    end else if (ticks_nxt > TICK_W'(to_r)) begin
      item_o.status = ST_STALE;
    end else begin
      item_o.status = ST_RUNNING;
    end
    item_o.count      = cnt_nxt;
    item_o.event_code = ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r    <= FS_RESET;
      to_r    <= TO_RESET;
      en_r    <= 1'b0;
      calc_r  <= '0;
      cal_r   <= 1'b0;
      cnt_r   <= '0;
      ticks_r <= '0;
      for (int i = 0; i < NCH; i++) begin
        zero_r[i] <= '0;
        sum_r[i]  <= '0;
        last_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_FULL_SCALE: fs_r <= cfg_pwdata[FS_W-1:0];
          REG_STALE_TO:   to_r <= cfg_pwdata[TO_W-1:0];
          REG_ENABLE:     en_r <= cfg_pwdata[0];
          default: ;
        endcase
      end
      calc_r  <= calc_nxt;
      cal_r   <= cal_nxt;
      cnt_r   <= cnt_nxt;
      ticks_r <= ticks_nxt;
      zero_r  <= zero_nxt;
      sum_r   <= sum_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ----- rtl/core/cscs_back.sv -----
// Back end: scales queued offset-corrected deltas to milliamps.
// Stage 1 multiplies by full scale, stage 2 divides by 65535 into the output register.
// Depends on cscs_pkg.
module cscs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cscs_pkg::fifo_stat_t              fifo_stat_i,
  input  cscs_pkg::item_t                   item_i,
  output logic                              pop_o,
  input  logic [cscs_pkg::FS_W-1:0]         full_scale_i,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cscs_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import cscs_pkg::*;

  // truncating divide of a product (|p| < 2^31) by 65535:
  // p = t*65536 + lo = t*65535 + (t + lo), and t + lo stays below 2*65535
  function automatic logic [CUR_W-1:0] div_fs(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [CUR_W-1:0]  t;
    logic [CUR_W:0]    r;
    logic [CUR_W-1:0]  q;
    mag = p[PROD_W-1] ? (~p + 1'b1) : p;
    t   = mag[PROD_W-1:PROD_W-CUR_W];
    r   = {1'b0, mag[CUR_W-1:0]} + {1'b0, t};
    q   = t + CUR_W'(r >= (CUR_W+1)'(ADC_FULL_SCALE));
    return p[PROD_W-1] ? (~q + 1'b1) : q;
  endfunction

  logic                     s1_v_r;
  logic [PROD_W-1:0]        s1_prod_r [NCH];
  logic [PROD_W-1:0]        s1_prod_nxt [NCH];
  logic [STAT_W-1:0]        s1_status_r;
  logic [CNT_W-1:0]         s1_count_r;
  logic [EV_W-1:0]          s1_ev_r;
  logic                     out_v_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic [OUT_TDATA_W-1:0]   out_data_nxt;
  logic                     s2_ready;
  logic                     s1_ready;
  logic signed [DELTA_W+FS_W:0] prod_full [NCH];

  assign s2_ready   = !out_v_r || out_tready;
  assign s1_ready   = !s1_v_r || s2_ready;
  assign pop_o      = s1_ready && !fifo_stat_i.empty;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      prod_full[i]   = $signed(item_i.delta[i]) * $signed({1'b0, full_scale_i});
      s1_prod_nxt[i] = prod_full[i][PROD_W-1:0];
    end
  end

  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < NCH; i++) begin
      out_data_nxt[i*CUR_W +: CUR_W] = div_fs(s1_prod_r[i]);
    end
    out_data_nxt[STAT_LSB +: STAT_W] = s1_status_r;
    out_data_nxt[SCNT_LSB +: CNT_W]  = s1_count_r;
    out_data_nxt[EV_LSB +: EV_W]     = s1_ev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= !fifo_stat_i.empty;
      end
      if (s2_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      s1_prod_r   <= s1_prod_nxt;
      s1_status_r <= item_i.status;
      s1_count_r  <= item_i.count;
      s1_ev_r     <= item_i.event_code;
    end
    if (s1_v_r && s2_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- rtl/core/current_sense_offset_calibrate_scale_core.sv -----
// Current-sense offset calibration and scaling core (top level).
// Path: queue write, multiply stage, divide-by-65535 stage, output register.
// Throughput: one request per cycle while the queue has room; a four-entry queue
// absorbs output stalls. Reset: synchronous active-low rst_n clears all state but
// queue and pipeline data, and restores register defaults.
// Depends on cscs_pkg, cscs_front, cscs_fifo, cscs_back.
module current_sense_offset_calibrate_scale_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cscs_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [cscs_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [cscs_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // raw_a, raw_b, raw_c, raw_d, raw_e, switching_active, zero fill
  input  logic [cscs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd
  input  logic [cscs_pkg::CMD_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // current_a..current_e, status, sample_count, calibration_event, zero fill
  output logic [cscs_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import cscs_pkg::*;

  fifo_stat_t        fifo_stat;
  item_t             push_item;
  item_t             pop_item;
  logic              push;
  logic              pop;
  logic [FS_W-1:0]   full_scale;
  logic [STAT_W-1:0] out_status;
  logic [EV_W-1:0]   out_event;

  assign cfg_pready = 1'b1;

  cscs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .item_o       (push_item),
    .full_scale_o (full_scale)
  );

  cscs_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_item),
    .pop_i       (pop),
    .pop_data_o  (pop_item),
    .stat_o      (fifo_stat)
  );

  cscs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .fifo_stat_i  (fifo_stat),
    .item_i       (pop_item),
    .pop_o        (pop),
    .full_scale_i (full_scale),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

  assign out_status = out_tdata[STAT_LSB +: STAT_W];
  assign out_event  = out_tdata[EV_LSB +: EV_W];

  ap_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");

  ap_done_leaves_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_event == EV_DONE |-> out_status != ST_CAL)
    else $error("finished calibration still reports calibrating");

  ap_accept_enters_cal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_event == EV_ACCEPT |-> out_status == ST_CAL)
    else $error("accepted calibration does not report calibrating");

  ap_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.full |-> !push)
    else $error("request queued while queue full");

endmodule
